@@ sv/ascending_sort_engine_unit_defines.svh @@
// assertion macros for the sort engine rtl
`ifndef ASCENDING_SORT_ENGINE_UNIT_DEFINES_SVH
`define ASCENDING_SORT_ENGINE_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define ASE_CHECK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASE_CHECK_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASE_CHECK(lbl, clk, rst, prop, msg)
`define ASE_CHECK_NR(lbl, clk, prop, msg)
`endif

`endif

@@ sv/ase_pkg.sv @@
// shared types and constants of the sort engine
`default_nettype none
package ase_pkg;

  localparam int WORD_W       = 32;
  localparam int SIZE_DEFAULT = 32;

  typedef struct packed {
    logic signed [WORD_W-1:0] value;
    logic                     last_in;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] sorted_value;
    logic                     last_out;
    logic                     overflowed;
  } out_item_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic                     insert;
    logic                     shift;
    logic signed [WORD_W-1:0] key;
  } cell_ctrl_t;

endpackage
`default_nettype wire

@@ sv/ascending_sort_engine_unit.sv @@
// channel  | signals                 | transfer when
// ---------+-------------------------+------------------------------
// input    | start, busy, item       | start high while busy low
// result   | strobe, result          | every cycle strobe is high
//
// an input value is inserted into the cell chain in the cycle it is taken,
// so values not marked last go at one per cycle with busy staying low.
// the value marked last is inserted, then the held set drains from the head
// of the chain, one result per cycle until the set is out, busy high all the while.
// results cannot be held off; strobe marks each one for a single cycle.
// synchronous reset empties the chain and clears count and overflow flag.
`default_nettype none
`include "ascending_sort_engine_unit_defines.svh"
module ascending_sort_engine_unit
  import ase_pkg::*;
#(
  parameter int SIZE = SIZE_DEFAULT
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  output logic          busy,
  input  wire in_item_t item,
  output logic          strobe,
  output out_item_t     result
);

  localparam int CNT_W = $clog2(SIZE + 1);

  typedef enum logic {FILL, DRAIN} state_t;

  state_t                   state;
  logic [CNT_W-1:0]         count;
  logic                     ovf;
  logic                     take;
  logic                     has_room;
  cell_ctrl_t               ctrl;
  logic signed [WORD_W-1:0] head_value;

  assign take     = start && (state == FILL);
  assign has_room = count < CNT_W'(SIZE);

  assign ctrl.insert = take && has_room;
  assign ctrl.shift  = (state == DRAIN);
  assign ctrl.key    = item.value;

  ase_chain #(.SIZE(SIZE)) u_chain (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .head_value (head_value)
  );

  assign busy                = (state == DRAIN);
  assign strobe              = (state == DRAIN);
  assign result.sorted_value = head_value;
  assign result.last_out     = (count == CNT_W'(1));
  assign result.overflowed   = ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FILL;
      count <= '0;
      ovf   <= 1'b0;
    end else begin
      case (state)
        FILL: begin
          if (take) begin
            if (has_room) begin
              count <= count + CNT_W'(1);
            end else begin
              ovf <= 1'b1;
            end
            if (item.last_in) begin
              state <= DRAIN;
            end
          end
        end
        DRAIN: begin
          count <= count - CNT_W'(1);
          if (count == CNT_W'(1)) begin
            state <= FILL;
            ovf   <= 1'b0;
          end
        end
        default: begin
          state <= FILL;
        end
      endcase
    end
  end

  `ASE_CHECK(a_strobe_has_data, clk, rst, strobe |-> (count != '0), "result with empty chain")
  `ASE_CHECK(a_last_ends_set, clk, rst, (strobe && result.last_out) |=> !busy, "busy after last result")
  `ASE_CHECK(a_more_follows, clk, rst, (strobe && !result.last_out) |=> strobe, "gap inside a set")
  `ASE_CHECK(a_close_drains, clk, rst, (start && !busy && item.last_in) |=> strobe, "closing item gave no drain")
  `ASE_CHECK(a_ovf_full, clk, rst, ((state == FILL) && ovf) |-> (count == CNT_W'(SIZE)), "overflow below capacity")

endmodule
`default_nettype wire

@@ sv/ase_cell.sv @@
// one cell of the insertion chain: holds one value and its valid bit
`default_nettype none
module ase_cell
  import ase_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire cell_ctrl_t               ctrl,
  input  wire logic                     left_gt,
  input  wire logic                     left_valid,
  input  wire logic signed [WORD_W-1:0] left_value,
  input  wire logic                     right_valid,
  input  wire logic signed [WORD_W-1:0] right_value,
  output logic                          gt,
  output logic                          valid,
  output logic signed [WORD_W-1:0]      value
);

  // equal values stay put, so a new value lands behind them
  assign gt = valid && (value > ctrl.key);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.shift) begin
      valid <= right_valid;
    end else if (ctrl.insert) begin
      valid <= valid || left_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      value <= right_value;
    end else if (ctrl.insert && (gt || !valid)) begin
      value <= left_gt ? left_value : ctrl.key;
    end
  end

endmodule
`default_nettype wire

@@ sv/ase_chain.sv @@
// row of insertion cells, smallest value at the head
`default_nettype none
module ase_chain
  import ase_pkg::*;
#(
  parameter int SIZE = SIZE_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire cell_ctrl_t          ctrl,
  output logic signed [WORD_W-1:0] head_value
);

  logic                     gt    [SIZE];
  logic                     valid [SIZE];
  logic signed [WORD_W-1:0] value [SIZE];

  for (genvar i = 0; i < SIZE; i++) begin : g_cell
    logic                     l_gt;
    logic                     l_valid;
    logic signed [WORD_W-1:0] l_value;
    logic                     r_valid;
    logic signed [WORD_W-1:0] r_value;

    if (i == 0) begin : g_head
      assign l_gt    = 1'b0;
      assign l_valid = 1'b1;
      assign l_value = ctrl.key;
    end else begin : g_body
      assign l_gt    = gt[i-1];
      assign l_valid = valid[i-1];
      assign l_value = value[i-1];
    end

    if (i == SIZE - 1) begin : g_tail
      assign r_valid = 1'b0;
      assign r_value = '0;
    end else begin : g_inner
      assign r_valid = valid[i+1];
      assign r_value = value[i+1];
    end

    ase_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .left_gt     (l_gt),
      .left_valid  (l_valid),
      .left_value  (l_value),
      .right_valid (r_valid),
      .right_value (r_value),
      .gt          (gt[i]),
      .valid       (valid[i]),
      .value       (value[i])
    );
  end

  assign head_value = value[0];

endmodule
`default_nettype wire

@@ verif/tb_top.sv @@
// testbench for the sort engine: a directed table, then random sets, checked against a predictor
`default_nettype none
module tb_top;
  import ase_pkg::*;

  localparam int SIZE         = SIZE_DEFAULT;
  localparam int RANDOM_ITEMS = 250;
  localparam int SETTLE_WAIT  = 2 * SIZE + 8;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int NUM_ROWS     = 24;

  localparam logic signed [WORD_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [WORD_W-1:0] VAL_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [WORD_W-1:0] value;
    bit                       last_in;
    bit                       typed;
    logic signed [WORD_W-1:0] want_value;
    bit                       want_last;
    bit                       want_ovf;
  } stim_row_t;

  logic      clk   = 1'b0;
  logic      rst   = 1'b1;
  logic      start = 1'b0;
  in_item_t  item  = '0;
  logic      busy;
  logic      strobe;
  out_item_t result;

  // sorted copy of the set being gathered, stable for equal values
  logic signed [WORD_W-1:0] held_vals[$];
  logic                     drop_seen = 1'b0;
  out_item_t                fresh_results[$];
  out_item_t                sorted_out_q[$];

  int error_count = 0;
  int cycle_count = 0;
  int idle_pct    = 0;

  // typed rows are single-value sets: the value comes straight back, marked last
  stim_row_t dir_rows [NUM_ROWS] = '{
    '{VAL_MAX, 1'b1, 1'b1, VAL_MAX, 1'b1, 1'b0},
    '{VAL_MIN, 1'b1, 1'b1, VAL_MIN, 1'b1, 1'b0},
    '{32'sd0,  1'b1, 1'b1, 32'sd0,  1'b1, 1'b0},
    '{-32'sd1, 1'b1, 1'b1, -32'sd1, 1'b1, 1'b0},
    '{32'sd1,  1'b1, 1'b1, 32'sd1,  1'b1, 1'b0},
    // mixed set with duplicates and both extremes
    '{32'sd5,  1'b0, 1'b0, '0, 1'b0, 1'b0},
    '{-32'sd3, 1'b0, 1'b0, '0, 1'b0, 1'b0},
    '{32'sd5,  1'b0, 1'b0, '0, 1'b0, 1'b0},
    '{VAL_MIN, 1'b0, 1'b0, '0, 1'b0, 1'b0},
    '{VAL_MAX, 1'b0, 1'b0, '0, 1'b0, 1'b0},
    '{32'sd0,  1'b0, 1'b0, '0, 1'b0, 1'b0},
    '{-32'sd3, 1'b1, 1'b0, '0, 1'b0, 1'b0},
    // already ascending
    '{-32'sd2, 1'b0, 1'b0, '0, 1'b0, 1'b0},
    '{-32'sd1, 1'b0, 1'b0, '0, 1'b0, 1'b0},
    '{32'sd0,  1'b0, 1'b0, '0, 1'b0, 1'b0},
    '{32'sd1,  1'b0, 1'b0, '0, 1'b0, 1'b0},
    '{32'sd2,  1'b1, 1'b0, '0, 1'b0, 1'b0},
    // descending
    '{32'sd9,  1'b0, 1'b0, '0, 1'b0, 1'b0},
    '{32'sd4,  1'b0, 1'b0, '0, 1'b0, 1'b0},
    '{-32'sd4, 1'b0, 1'b0, '0, 1'b0, 1'b0},
    '{-32'sd9, 1'b1, 1'b0, '0, 1'b0, 1'b0},
    // all equal
    '{32'sd3,  1'b0, 1'b0, '0, 1'b0, 1'b0},
    '{32'sd3,  1'b0, 1'b0, '0, 1'b0, 1'b0},
    '{32'sd3,  1'b1, 1'b0, '0, 1'b0, 1'b0}
  };

  always #4 clk = ~clk;

  ascending_sort_engine_unit #(.SIZE(SIZE)) DUT (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .strobe (strobe),
    .result (result)
  );

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    error_count++;
  endtask

  // insert behind equal values; a closing value flushes the whole set
  task automatic sort_insert_step(input in_item_t it);
    logic signed [WORD_W-1:0] v;
    int pos;
    out_item_t r;
    v = it.value;
    fresh_results.delete();
    if (held_vals.size() < SIZE) begin
      pos = held_vals.size();
      while (pos > 0 && held_vals[pos-1] > v) pos--;
      held_vals.insert(pos, v);
    end else begin
      drop_seen = 1'b1;
    end
    if (it.last_in) begin
      for (int k = 0; k < held_vals.size(); k++) begin
        r.sorted_value = held_vals[k];
        r.last_out     = (k == held_vals.size() - 1);
        r.overflowed   = drop_seen;
        fresh_results.push_back(r);
      end
      held_vals.delete();
      drop_seen = 1'b0;
    end
  endtask

  // one input transfer; start stays high until an edge sees busy low
  task automatic send_item(input in_item_t it, input bit typed, input out_item_t typed_res);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
    sort_insert_step(it);
    if (typed) sorted_out_q.push_back(typed_res);
    else foreach (fresh_results[k]) sorted_out_q.push_back(fresh_results[k]);
  endtask

  function automatic logic signed [WORD_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return VAL_MAX;
      1:       return VAL_MIN;
      2, 3:    return WORD_W'(int'($urandom_range(6)) - 3);
      default: return $urandom();
    endcase
  endfunction

  function automatic int pick_set_size(input int set_idx);
    int r;
    if (set_idx == 0) return SIZE;
    if (set_idx == 1) return SIZE + 3;
    r = $urandom_range(99);
    if (r < 75) return $urandom_range(8, 1);
    if (r < 90) return $urandom_range(SIZE - 1, 9);
    return $urandom_range(SIZE + 4, SIZE - 1);
  endfunction

  initial begin
    in_item_t  it;
    out_item_t want;
    int        sent;
    int        set_idx;
    int        set_len;
    int        idle_phases [3];
    idle_phases = '{0, 84, 13};
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NUM_ROWS; i++) begin
      it.value          = dir_rows[i].value;
      it.last_in        = dir_rows[i].last_in;
      want.sorted_value = dir_rows[i].want_value;
      want.last_out     = dir_rows[i].want_last;
      want.overflowed   = dir_rows[i].want_ovf;
      send_item(it, dir_rows[i].typed, want);
    end

    sent    = 0;
    set_idx = 0;
    want    = '0;
    while (sent < RANDOM_ITEMS) begin
      idle_pct = idle_phases[(set_idx / 6) % 3];
      set_len  = pick_set_size(set_idx);
      for (int k = 0; k < set_len; k++) begin
        it.value   = pick_value();
        it.last_in = (k == set_len - 1);
        send_item(it, 1'b0, want);
        sent++;
      end
      set_idx++;
    end
    start <= 1'b0;

    wait (sorted_out_q.size() == 0);
    repeat (SETTLE_WAIT) @(posedge clk);
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // every strobed cycle is a result transfer
  always @(posedge clk) begin : result_check
    out_item_t due;
    if (!rst && strobe) begin
      if (sorted_out_q.size() == 0) begin
        report_mismatch($sformatf("result %0d with nothing due", result.sorted_value));
      end else begin
        due = sorted_out_q.pop_front();
        if (result.sorted_value !== due.sorted_value)
          report_mismatch($sformatf("sorted_value %0d, due %0d",
                                    result.sorted_value, due.sorted_value));
        if (result.last_out !== due.last_out)
          report_mismatch($sformatf("last_out %b, due %b", result.last_out, due.last_out));
        if (result.overflowed !== due.overflowed)
          report_mismatch($sformatf("overflowed %b, due %b",
                                    result.overflowed, due.overflowed));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due",
               cycle_count, sorted_out_q.size());
      $display("Mismatches found");
      $finish;
    end
  end

endmodule
`default_nettype wire
